>>> sv/kfh_pkg.sv
// Shared types, constants and Q16.16 helpers for the keyframe Hermite channel.
// No dependencies.
package kfh_pkg;

  localparam int unsigned CfgW       = 9;
  localparam int unsigned NumW       = 49;
  localparam int unsigned DenW       = 33;
  localparam int unsigned DivSteps   = NumW;
  // interval / 30 as ((interval / 2) * ceil(2^35 / 15)) >> 35
  localparam logic [31:0] DtsRecip   = 32'h8888_8889;
  localparam int unsigned DtsShift   = 35;

  localparam logic [2:0] KIND_EXACT  = 3'd0;
  localparam logic [2:0] KIND_BEFORE = 3'd1;
  localparam logic [2:0] KIND_INTERP = 3'd2;
  localparam logic [2:0] KIND_PAST   = 3'd3;
  localparam logic [2:0] KIND_EMPTY  = 3'd4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_WALK, ST_LAST, ST_FETCH_A, ST_DIV_S, ST_DIV_T, ST_MUL
  } state_e;

  typedef enum logic [2:0] {
    MS_S2, MS_S3, MS_F, MS_H, MS_T1, MS_M1, MS_T2, MS_SUM
  } mul_step_e;

  typedef struct packed {
    logic [31:0]        key_time;
    logic [1:0]         value_count;
    logic signed [31:0] v1;
    logic signed [31:0] v2;
    logic signed [31:0] v3;
  } key_entry_t;

  typedef struct packed {
    logic signed [31:0] tin;
    logic signed [31:0] tout;
    logic signed [31:0] val;
  } key_view_t;

  typedef struct packed {
    logic                   start;
    logic signed [NumW-1:0] num;
    logic signed [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quo;
  } div_rsp_t;

  function automatic key_view_t decode_key(key_entry_t e);
    key_view_t r;
    unique case (e.value_count)
      2'd0:    r = '{tin: 32'sd0, tout: 32'sd0, val: 32'sd0};
      2'd1:    r = '{tin: 32'sd0, tout: 32'sd0, val: e.v1};
      2'd2:    r = '{tin: e.v1, tout: e.v1, val: e.v2};
      default: r = '{tin: e.v1, tout: e.v2, val: e.v3};
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat33(logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > 33'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -33'sh0_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] qadd(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    return sat33(s);
  endfunction

  function automatic logic signed [31:0] qsub(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) - 33'(b);
    return sat33(s);
  endfunction

  function automatic logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] p;
    logic signed [47:0] q;
    logic signed [31:0] r;
    p = 64'(a) * 64'(b);
    q = p[63:16];
    if (q > 48'sh0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (q < -48'sh0000_8000_0000) r = 32'sh8000_0000;
    else r = q[31:0];
    return r;
  endfunction

endpackage

>>> sv/kfh_if.sv
// Valid/ready channel interfaces for query words and result words.
// Depends on nothing.
interface kfh_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  entry_index;
  logic [31:0] key_time;
  logic [1:0]  value_count;
  logic signed [31:0] first_value;
  logic signed [31:0] second_value;
  logic signed [31:0] third_value;
  logic [31:0] query_time;
  modport source (output valid, operation, entry_index, key_time, value_count,
                  first_value, second_value, third_value, query_time, input ready);
  modport sink (input valid, operation, entry_index, key_time, value_count,
                first_value, second_value, third_value, query_time, output ready);
endinterface

interface kfh_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] channel_value;
  logic [2:0]  case_kind;
  modport source (output valid, channel_value, case_kind, input ready);
  modport sink (input valid, channel_value, case_kind, output ready);
endinterface

>>> sv/keyframe_hermite_channel_core.sv
// Keyframe Hermite channel: top level, sequencer and shared Q16.16 multiplier.
// Depends on kfh_pkg, kfh_if, kfh_key_mem and kfh_div.
//
// Usage: in_i carries load words (operation 0) and evaluate words (operation 1);
// out_o returns one result word per evaluate, none per load. cfg_we_i/cfg_wdata_i
// set the key count while the block is idle.
// One word is in flight at a time; in_i.ready is high only when the sequencer is
// idle and the result register is empty, so loads can follow one per cycle.
// Path from the accepting edge to the result word: registered at that edge
// for an empty channel; an exact, before-first or past-last answer walks the
// keys from the cursor, one key per cycle through the single read port of the
// key memory. An interpolation adds a fetch state, the serial divider, a state
// scaling the interval by 1/30 and 8 multiplier steps; the divider and the
// scaling are skipped when the interval is zero.
// Reset clears the cursor, the key count and all control; key memory contents
// are undefined until loaded. A stalled receiver holds the result word and
// blocks further input until it is taken.
module keyframe_hermite_channel_core import kfh_pkg::*; #(
  parameter int unsigned MAX_KEYS = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  kfh_in_if.sink          in_i,
  kfh_out_if.source       out_o
);

  localparam int unsigned Aw = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned Cw = $clog2(MAX_KEYS + 1);
  localparam int unsigned Lw = (Cw > CfgW) ? Cw : CfgW;

  state_e    state_q, state_d;
  mul_step_e step_q, step_d;

  logic [CfgW-1:0] count_q, count_d;
  logic [Cw-1:0]   cursor_q, cursor_d, k_q, k_d;
  logic [Lw-1:0]   cnt_q, cnt_d, cnt_now;
  logic [31:0]     t_q, t_d, tb_q, tb_d;
  logic signed [31:0] zb_q, zb_d, vb_q, vb_d, va_q, va_d, za_q, za_d;
  logic signed [31:0] dv_q, dv_d, zs_q, zs_d, s_q, s_d, dts_q, dts_d;
  logic signed [31:0] s2_q, s2_d, s3_q, s3_d, f0_q, f0_d, f5_q, f5_d, h_q, h_d;
  logic signed [31:0] t1_q, t1_d, m1_q, m1_d, m2_q, m2_d, t2_q, t2_d;
  logic signed [DenW-1:0] dt_q, dt_d, dt_w, u_w;
  logic [31:0]     dtm_q, dtm_d;
  logic            ov_q, ov_d;
  logic signed [31:0] oval_q, oval_d;
  logic [2:0]      okind_q, okind_d;

  logic            we;
  logic [Aw-1:0]   raddr;
  key_entry_t      wdata, rdata;
  key_view_t       rview;
  div_req_t        dreq;
  div_rsp_t        drsp;
  logic signed [31:0] mul_a, mul_b, prod;
  logic [Cw-1:0]   kn;
  logic [DenW-1:0] dt_abs;
  logic [63:0]     dts_p;
  logic signed [31:0] dts_mag;

  kfh_key_mem #(.Depth(MAX_KEYS), .Aw(Aw)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (Aw'(in_i.entry_index)),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  kfh_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  assign wdata = '{key_time: in_i.key_time, value_count: in_i.value_count,
                   v1: in_i.first_value, v2: in_i.second_value, v3: in_i.third_value};
  assign rview   = decode_key(rdata);
  assign cnt_now = (Lw'(count_q) < Lw'(MAX_KEYS)) ? Lw'(count_q) : Lw'(MAX_KEYS);
  assign kn      = k_q + Cw'(1);
  assign dt_w    = $signed({1'b0, tb_q}) - $signed({1'b0, rdata.key_time});
  assign u_w     = $signed({1'b0, t_q}) - $signed({1'b0, rdata.key_time});
  assign prod    = qmul(mul_a, mul_b);
  assign dt_abs  = dt_q[DenW-1] ? DenW'(-dt_q) : DenW'(dt_q);
  assign dts_p   = 64'(dtm_q) * 64'(DtsRecip);
  assign dts_mag = 32'(dts_p >> DtsShift);

  assign in_i.ready          = (state_q == ST_IDLE) && !ov_q;
  assign out_o.valid         = ov_q;
  assign out_o.channel_value = oval_q;
  assign out_o.case_kind     = okind_q;

  always_comb begin
    unique case (step_q)
      MS_S2:   begin mul_a = s_q;   mul_b = s_q;  end
      MS_S3:   begin mul_a = s_q;   mul_b = s2_q; end
      MS_H:    begin mul_a = za_q;  mul_b = f0_q; end
      MS_T1:   begin mul_a = h_q;   mul_b = dv_q; end
      MS_M1:   begin mul_a = f5_q;  mul_b = zs_q; end
      MS_T2:   begin mul_a = dts_q; mul_b = qsub(m1_q, m2_q); end
      default: begin mul_a = s_q;   mul_b = s_q;  end
    endcase
  end

  always_comb begin
    state_d = state_q;  step_d = step_q;
    count_d = count_q;  cursor_d = cursor_q; k_d = k_q; cnt_d = cnt_q;
    t_d = t_q; tb_d = tb_q; zb_d = zb_q; vb_d = vb_q; va_d = va_q; za_d = za_q;
    dv_d = dv_q; zs_d = zs_q; s_d = s_q; dts_d = dts_q; dt_d = dt_q; dtm_d = dtm_q;
    s2_d = s2_q; s3_d = s3_q; f0_d = f0_q; f5_d = f5_q; h_d = h_q;
    t1_d = t1_q; m1_d = m1_q; m2_d = m2_q; t2_d = t2_q;
    ov_d = ov_q; oval_d = oval_q; okind_d = okind_q;
    we    = 1'b0;
    raddr = Aw'(k_q);
    dreq  = '{start: 1'b0, num: '0, den: '0};

    if (out_o.valid && out_o.ready) ov_d = 1'b0;
    if (cfg_we_i) count_d = cfg_wdata_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid && in_i.ready) begin
          if (in_i.operation == OP_LOAD) begin
            we       = Lw'(in_i.entry_index) < Lw'(MAX_KEYS);
            cursor_d = '0;
          end else begin
            t_d   = in_i.query_time;
            cnt_d = cnt_now;
            k_d   = cursor_q;
            if (cnt_now == '0) begin
              ov_d = 1'b1; oval_d = 32'sd0; okind_d = KIND_EMPTY;
            end else if (Lw'(cursor_q) >= cnt_now) begin
              raddr   = Aw'(cnt_now - Lw'(1));
              state_d = ST_LAST;
            end else begin
              raddr   = Aw'(cursor_q);
              state_d = ST_WALK;
            end
          end
        end
      end
      ST_WALK: begin
        if (rdata.key_time == t_q) begin
          ov_d = 1'b1; oval_d = rview.val; okind_d = KIND_EXACT;
          cursor_d = k_q; state_d = ST_IDLE;
        end else if (rdata.key_time > t_q) begin
          cursor_d = k_q;
          if (k_q == '0) begin
            ov_d = 1'b1; oval_d = rview.val; okind_d = KIND_BEFORE;
            state_d = ST_IDLE;
          end else begin
            tb_d = rdata.key_time; zb_d = rview.tin; vb_d = rview.val;
            raddr   = Aw'(k_q - Cw'(1));
            state_d = ST_FETCH_A;
          end
        end else begin
          k_d = kn;
          if (Lw'(kn) < cnt_q) begin
            raddr = Aw'(kn);
          end else begin
            raddr   = Aw'(cnt_q - Lw'(1));
            state_d = ST_LAST;
          end
        end
      end
      ST_LAST: begin
        ov_d = 1'b1; oval_d = rview.val; okind_d = KIND_PAST;
        cursor_d = k_q; state_d = ST_IDLE;
      end
      ST_FETCH_A: begin
        va_d = rview.val; za_d = rview.tout; dt_d = dt_w;
        dv_d = qsub(rview.val, vb_q);
        zs_d = qadd(rview.tout, zb_q);
        if (dt_w != '0) begin
          dreq.start = 1'b1;
          dreq.num   = {u_w, 16'd0};
          dreq.den   = dt_w;
          state_d    = ST_DIV_S;
        end else begin
          s_d     = 32'sd0;
          dts_d   = 32'sd0;
          step_d  = MS_S2;
          state_d = ST_MUL;
        end
      end
      ST_DIV_S: begin
        dtm_d = dt_abs[DenW-1:1];
        if (drsp.done) begin
          s_d     = drsp.quo;
          state_d = ST_DIV_T;
        end
      end
      ST_DIV_T: begin
        dts_d   = dt_q[DenW-1] ? -dts_mag : dts_mag;
        step_d  = MS_S2;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        unique case (step_q)
          MS_S2:  begin s2_d = prod; step_d = MS_S3; end
          MS_S3:  begin s3_d = prod; step_d = MS_F; end
          MS_F:   begin
            f0_d = qsub(s2_q, s_q); f5_d = qsub(s3_q, s2_q); step_d = MS_H;
          end
          MS_H:   begin
            h_d = qsub(qadd(f5_q, f5_q), s2_q); m2_d = prod; step_d = MS_T1;
          end
          MS_T1:  begin t1_d = prod; step_d = MS_M1; end
          MS_M1:  begin m1_d = prod; step_d = MS_T2; end
          MS_T2:  begin t2_d = prod; step_d = MS_SUM; end
          MS_SUM: begin
            ov_d = 1'b1; oval_d = qadd(qadd(va_q, t1_q), t2_q); okind_d = KIND_INTERP;
            state_d = ST_IDLE;
          end
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= MS_S2;
      count_q  <= '0;
      cursor_q <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d; cnt_q <= cnt_d; t_q <= t_d; tb_q <= tb_d;
    zb_q <= zb_d; vb_q <= vb_d; va_q <= va_d; za_q <= za_d;
    dv_q <= dv_d; zs_q <= zs_d; s_q <= s_d; dts_q <= dts_d; dt_q <= dt_d;
    dtm_q <= dtm_d;
    s2_q <= s2_d; s3_q <= s3_d; f0_q <= f0_d; f5_q <= f5_d; h_q <= h_d;
    t1_q <= t1_d; m1_q <= m1_d; m2_q <= m2_d; t2_q <= t2_d;
    oval_q <= oval_d; okind_q <= okind_d;
  end

endmodule

>>> sv/kfh_key_mem.sv
// Keyframe store: one write port, one read port, registered read data.
// Depends on kfh_pkg.
module kfh_key_mem import kfh_pkg::*; #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Aw    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  key_entry_t    wdata_i,
  input  logic [Aw-1:0] raddr_i,
  output key_entry_t    rdata_o
);

  key_entry_t mem_q [Depth];
  key_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/kfh_div.sv
// Radix-2 restoring signed divider, one quotient bit a cycle, saturated to 32 bits.
// Depends on kfh_pkg.
module kfh_div import kfh_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic            busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic [5:0]      cnt_q, cnt_d;
  logic [NumW-1:0] n_q, n_d, quo_q, quo_d;
  logic [DenW-1:0] d_q, d_d, rem_q, rem_d;
  logic signed [31:0] res_q, res_d;
  logic [DenW:0]   rem_sh;
  logic [NumW-1:0] quo_nx;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    n_d    = n_q;
    d_d    = d_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    res_d  = res_q;
    rem_sh = {rem_q, n_q[NumW-1]};
    quo_nx = {quo_q[NumW-2:0], 1'b0};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = req_i.num[NumW-1] ^ req_i.den[DenW-1];
      n_d    = req_i.num[NumW-1] ? NumW'(-req_i.num) : NumW'(req_i.num);
      d_d    = req_i.den[DenW-1] ? DenW'(-req_i.den) : DenW'(req_i.den);
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, d_q}) begin
        rem_d  = DenW'(rem_sh - {1'b0, d_q});
        quo_nx = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DenW-1:0];
      end
      quo_d = quo_nx;
      n_d   = {n_q[NumW-2:0], 1'b0};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (!neg_q) begin
          res_d = (quo_nx > NumW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : quo_nx[31:0];
        end else begin
          res_d = (quo_nx > NumW'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                     : 32'(-quo_nx[31:0]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    n_q   <= n_d;
    d_q   <= d_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    res_q <= res_d;
  end

  assign rsp_o = '{done: done_q, quo: res_q};

endmodule

>>> sv/kfh_checker.sv
// Port-level checks for keyframe_hermite_channel_core, bound to the top level.
// Depends on kfh_pkg.
module kfh_checker import kfh_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_operation_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] out_kind_i
);

  // one word in flight: no input taken while a result waits
  a_single_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("input ready with result pending");

  // loads never produce a result word
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_operation_i == OP_LOAD) |=> !out_valid_i)
    else $error("result after load");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_kind_i == KIND_EXACT || out_kind_i == KIND_BEFORE ||
                     out_kind_i == KIND_INTERP || out_kind_i == KIND_PAST ||
                     out_kind_i == KIND_EMPTY)) else $error("bad case kind");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i) else $error("result dropped");

endmodule

bind keyframe_hermite_channel_core kfh_checker u_kfh_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_operation_i (in_i.operation),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_kind_i     (out_o.case_kind)
);
